// ===== rtl/mtc_pkg.sv =====
package mtc_pkg;

    localparam int KEY_W    = 32;
    localparam int CLASS_W  = 32;
    localparam int MAJOR_W  = 16;
    localparam int STATUS_W = 3;

    typedef logic [1:0] t_action;
    localparam t_action ACT_CLASSIFY = 2'd0;
    localparam t_action ACT_INSERT   = 2'd1;
    localparam t_action ACT_DELETE   = 2'd2;
    localparam t_action ACT_CLEAR    = 2'd3;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_HIT      = 3'd0;
    localparam t_status ST_FALLBACK = 3'd1;
    localparam t_status ST_NOMATCH  = 3'd2;
    localparam t_status ST_DONE     = 3'd3;
    localparam t_status ST_ZEROKEY  = 3'd4;
    localparam t_status ST_FULL     = 3'd5;
    localparam t_status ST_NOTFOUND = 3'd6;

    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_QUEUE_MAJOR = 2'd0;

    typedef struct packed {
        t_action             action;
        logic [KEY_W-1:0]    mark_key;
        logic [CLASS_W-1:0]  class_value;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [CLASS_W-1:0]  class_out;
    } t_out_item;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

// ===== rtl/mtc_ram.sv =====
module mtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mtc_fifo.sv =====
module mtc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= n_wr;
            end
            if (pop_ok) begin
                r_rd <= n_rd;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/mtc_front.sv =====
module mtc_front
    import mtc_pkg::*;
#(
    parameter int BUCKETS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  t_in_item                   i_item,
    input  t_back_status               i_back,
    output logic                       o_push,
    output t_in_item                   o_item,
    output logic [$clog2(BUCKETS)-1:0] o_bucket,
    input  logic                       i_full
);

    localparam int BW   = $clog2(BUCKETS);
    localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            // bucket is the low bits of the key
            assign o_stall  = i_full || i_back.init_busy;
            assign o_push   = i_valid && !o_stall;
            assign o_item   = i_item;
            assign o_bucket = i_item.mark_key[BW-1:0];
        end else begin : g_reduce
            // fold the key bytes with their weights modulo BUCKETS, then reduce
            // the folded sum by a reciprocal multiply and one compare and subtract
            localparam int FW = 20;
            localparam int QW = FW - 4;
            localparam int SH = FW + BW;
            localparam int PW = SH + QW;
            localparam logic [BW-1:0] W1    = BW'(256 % BUCKETS);
            localparam logic [BW-1:0] W2    = BW'(65536 % BUCKETS);
            localparam logic [BW-1:0] W3    = BW'(16777216 % BUCKETS);
            localparam logic [PW-1:0] RECIP = PW'((64'd1 << SH) / BUCKETS);

            logic          r_busy;
            logic [1:0]    r_step;
            t_in_item      r_item;
            logic [FW-1:0] r_fold;
            logic [QW-1:0] r_quot;
            logic [BW-1:0] r_rem;
            logic [FW-1:0] n_fold;
            logic [PW-1:0] prod;
            logic [FW-1:0] diff;
            logic [BW-1:0] n_rem;
            logic          accept, done;

            assign o_stall  = r_busy || i_back.init_busy;
            assign accept   = i_valid && !o_stall;
            assign done     = r_busy && (r_step == 2'd2);
            assign o_push   = done && !i_full;
            assign o_item   = r_item;
            assign o_bucket = r_rem;

            assign n_fold = FW'(i_item.mark_key[7:0])
                          + FW'(i_item.mark_key[15:8]) * FW'(W1)
                          + FW'(i_item.mark_key[23:16]) * FW'(W2)
                          + FW'(i_item.mark_key[31:24]) * FW'(W3);

            // quotient estimate is exact or one short
            assign prod  = PW'(r_fold) * RECIP;
            assign diff  = r_fold - FW'(r_quot) * FW'(BUCKETS);
            assign n_rem = (diff >= FW'(BUCKETS)) ? BW'(diff - FW'(BUCKETS)) : BW'(diff);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end else if (accept) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                end else if (r_busy && !done) begin
                    r_step <= r_step + 2'd1;
                end else if (o_push) begin
                    r_busy <= 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (accept) begin
                    r_item <= i_item;
                    r_fold <= n_fold;
                end
                if (r_busy && (r_step == 2'd0)) begin
                    r_quot <= prod[SH +: QW];
                end
                if (r_busy && (r_step == 2'd1)) begin
                    r_rem <= n_rem;
                end
            end
        end
    endgenerate

endmodule

// ===== rtl/mtc_back.sv =====
module mtc_back
    import mtc_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  t_in_item                   i_head_item,
    input  logic [$clog2(BUCKETS)-1:0] i_head_bucket,
    output logic                       o_pop,
    input  logic [MAJOR_W-1:0]         i_queue_major,
    output logic                       o_valid,
    output t_out_item                  o_item,
    input  logic                       i_stall,
    output t_back_status               o_status
);

    localparam int BW = $clog2(BUCKETS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]      r_state;
    logic [BW-1:0]   r_sweep;
    logic            r_present;
    logic            r_out_valid;
    t_out_item       r_out;
    t_in_item        r_cmd;
    logic [BW-1:0]   r_bucket;

    logic [WAYS-1:0]         v_row, v_wdata;
    logic [WAYS*KEY_W-1:0]   k_row, k_wdata;
    logic [WAYS*CLASS_W-1:0] c_row, c_wdata;
    logic                    v_we, kc_we;
    logic [BW-1:0]           raddr, waddr;

    logic            can_load, sweep_last, eval_commit;
    logic [WAYS-1:0] match, tgt;
    logic            hit;
    logic [CLASS_W-1:0] hit_class;
    t_out_item       eval_out;
    logic            eval_v_we, eval_kc_we, eval_set_present;
    logic [WAYS-1:0] eval_v_row;

    assign can_load    = !r_out_valid || !i_stall;
    assign sweep_last  = (r_sweep == BW'(BUCKETS - 1));
    assign eval_commit = (r_state == S_EVAL) && can_load;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign raddr       = (r_state == S_IDLE) ? i_head_bucket : r_bucket;

    assign o_valid            = r_out_valid;
    assign o_item             = r_out;
    assign o_status.init_busy = (r_state == S_INIT);

    // bucket row: way compares in parallel, first free way for a new key
    always_comb begin
        logic found;
        found     = 1'b0;
        hit_class = '0;
        tgt       = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = v_row[w] && (k_row[w*KEY_W +: KEY_W] == r_cmd.mark_key);
            if (match[w]) begin
                hit_class = hit_class | c_row[w*CLASS_W +: CLASS_W];
            end
        end
        hit = |match;
        if (hit) begin
            tgt = match;
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !v_row[w]) begin
                    tgt[w] = 1'b1;
                    found  = 1'b1;
                end
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            k_wdata[w*KEY_W +: KEY_W] =
                tgt[w] ? r_cmd.mark_key : k_row[w*KEY_W +: KEY_W];
            c_wdata[w*CLASS_W +: CLASS_W] =
                tgt[w] ? r_cmd.class_value : c_row[w*CLASS_W +: CLASS_W];
        end
    end

    always_comb begin
        eval_out.status    = ST_NOMATCH;
        eval_out.class_out = '0;
        eval_v_we          = 1'b0;
        eval_kc_we         = 1'b0;
        eval_set_present   = 1'b0;
        eval_v_row         = v_row;
        unique case (r_cmd.action)
            ACT_CLASSIFY: begin
                if (r_present) begin
                    if (hit) begin
                        eval_out.status    = ST_HIT;
                        eval_out.class_out = hit_class;
                    end
                end else if ((r_cmd.mark_key != '0)
                        && ((r_cmd.mark_key[KEY_W-1 -: MAJOR_W] == '0)
                        || (r_cmd.mark_key[KEY_W-1 -: MAJOR_W] == i_queue_major))) begin
                    eval_out.status    = ST_FALLBACK;
                    eval_out.class_out = r_cmd.mark_key;
                end
            end
            ACT_INSERT: begin
                if (r_cmd.mark_key == '0) begin
                    eval_out.status = ST_ZEROKEY;
                end else if (|tgt) begin
                    eval_out.status  = ST_DONE;
                    eval_v_we        = 1'b1;
                    eval_kc_we       = 1'b1;
                    eval_set_present = 1'b1;
                    eval_v_row       = v_row | tgt;
                end else begin
                    eval_out.status = ST_FULL;
                end
            end
            ACT_DELETE: begin
                if (hit) begin
                    eval_out.status = ST_DONE;
                    eval_v_we       = 1'b1;
                    eval_v_row      = v_row & ~match;
                end else begin
                    eval_out.status = ST_NOTFOUND;
                end
            end
            ACT_CLEAR: begin
                eval_out.status = ST_DONE;
            end
        endcase
    end

    // sweeps write zero rows into the valid store
    always_comb begin
        if (r_state == S_EVAL) begin
            v_we    = eval_commit && eval_v_we;
            kc_we   = eval_commit && eval_kc_we;
            waddr   = r_bucket;
            v_wdata = eval_v_row;
        end else begin
            v_we    = (r_state == S_INIT) || (r_state == S_CLEAR);
            kc_we   = 1'b0;
            waddr   = r_sweep;
            v_wdata = '0;
        end
    end

    mtc_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (waddr),
        .i_wdata (v_wdata),
        .i_raddr (raddr),
        .o_rdata (v_row)
    );

    mtc_ram #(.WIDTH(WAYS*KEY_W), .DEPTH(BUCKETS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (kc_we),
        .i_waddr (waddr),
        .i_wdata (k_wdata),
        .i_raddr (raddr),
        .o_rdata (k_row)
    );

    mtc_ram #(.WIDTH(WAYS*CLASS_W), .DEPTH(BUCKETS)) u_class_ram (
        .i_clk   (i_clk),
        .i_we    (kc_we),
        .i_waddr (waddr),
        .i_wdata (c_wdata),
        .i_raddr (raddr),
        .o_rdata (c_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EVAL && can_load) || (r_state == S_FIN && can_load)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_sweep <= r_sweep + BW'(1);
                    if (sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        if (i_head_item.action == ACT_CLEAR) begin
                            r_state   <= S_CLEAR;
                            r_sweep   <= '0;
                            r_present <= 1'b0;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (can_load) begin
                        r_state <= S_IDLE;
                        if (eval_set_present) begin
                            r_present <= 1'b1;
                        end
                    end
                end
                S_CLEAR: begin
                    r_sweep <= r_sweep + BW'(1);
                    if (sweep_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd    <= i_head_item;
            r_bucket <= i_head_bucket;
        end
        if (eval_commit) begin
            r_out <= eval_out;
        end else if (r_state == S_FIN && can_load) begin
            r_out.status    <= ST_DONE;
            r_out.class_out <= '0;
        end
    end

endmodule

// ===== rtl/mark_to_class_hash_classifier.sv =====
// Mark-to-class classifier: maps a 32-bit packet mark to a 32-bit class id through a
// hashed exact-match table of BUCKETS rows with WAYS slots each, the bucket being the
// mark modulo BUCKETS. Each beat classifies, inserts or updates, deletes, or clears;
// every beat gives exactly one result beat. A front stage works out the bucket and
// feeds a two-entry queue; the back stage reads the whole bucket row in a single read
// through the registered read of the bucket memories, compares all ways at once and
// writes the row back. With a power-of-two bucket count the front is combinational;
// otherwise it registers the folded key, the quotient and the remainder in turn and
// takes no new beat until the bucket has gone into the queue. A clear walks the valid
// store one row a cycle. After reset the same walk runs over every row, during which
// no beat is accepted; queue_major can be written at any time over the register port.
module mark_to_class_hash_classifier
    import mtc_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int BW   = $clog2(BUCKETS);
    localparam int QW   = BW + $bits(t_in_item);

    logic [MAJOR_W-1:0] r_queue_major;
    t_back_status       back_status;
    logic               push, full, pop, empty;
    t_in_item           push_item, head_item;
    logic [BW-1:0]      push_bucket, head_bucket;
    logic [QW-1:0]      head_data;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_QUEUE_MAJOR) ? {16'd0, r_queue_major} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_major <= '0;
        end else if (psel && penable && pwrite && (paddr == ADDR_QUEUE_MAJOR)) begin
            r_queue_major <= pwdata[MAJOR_W-1:0];
        end
    end

    mtc_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_item   (i_in_data),
        .i_back   (back_status),
        .o_push   (push),
        .o_item   (push_item),
        .o_bucket (push_bucket),
        .i_full   (full)
    );

    mtc_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_bucket, push_item}),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_empty (empty)
    );

    assign head_bucket = head_data[QW-1 -: BW];
    assign head_item   = head_data[$bits(t_in_item)-1:0];

    mtc_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head_item   (head_item),
        .i_head_bucket (head_bucket),
        .o_pop         (pop),
        .i_queue_major (r_queue_major),
        .o_valid       (o_out_valid),
        .o_item        (o_out_data),
        .i_stall       (i_out_stall),
        .o_status      (back_status)
    );

endmodule
